@@ rtl/core/fva_pkg.sv @@
// Shared constants, types and tables for the FM voice allocator.
// Used by fva_ctrl, fva_dp and fm_voice_allocator_core; no dependencies.
package fva_pkg;

    localparam int VOICES      = 9;
    localparam int SHADOW_REGS = 64;
    localparam int SHADOW_AW   = $clog2(SHADOW_REGS);

    localparam int VOICE_W = 4;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 8;
    localparam int FNUM_W  = 9;
    localparam int VOL_W   = 4;
    localparam int KEY_W   = 7;
    localparam int VEL_W   = 7;
    localparam int TABLE_W = 15;

    // chip register bases, one register per voice above each
    localparam logic [ADDR_W-1:0] BASE_FHI = 6'h10;
    localparam logic [ADDR_W-1:0] BASE_KEY = 6'h20;
    localparam logic [ADDR_W-1:0] BASE_VOL = 6'h30;

    localparam logic [ADDR_W-1:0] ADDR_CTRL0 = 6'h00;
    localparam logic [ADDR_W-1:0] ADDR_CTRL1 = 6'h01;

    localparam logic [DATA_W-1:0] KEY_DOWN_BIT     = 8'h10;
    localparam logic [DATA_W-1:0] SETUP_CTRL_VAL   = 8'h20;
    localparam logic [DATA_W-1:0] SETUP_OCTAVE_VAL = 8'h60;
    localparam logic [VOL_W-1:0]  VOL_MAX          = 4'hF;

    typedef enum logic {
        CMD_NOTE_ON  = 1'b0,
        CMD_NOTE_OFF = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        KIND_WRITE     = 2'd0,
        KIND_NO_VOICE  = 2'd1,
        KIND_BAD_VOICE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        RD_KEY,
        RD_FHI,
        RD_VOL
    } rd_sel_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FLO,
        OP_FHI,
        OP_VOL,
        OP_KEY_ON,
        OP_KEY_OFF,
        OP_REJECT
    } dp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FLO,
        ST_FHI,
        ST_VOL,
        ST_KEY,
        ST_OFF,
        ST_REJECT
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    rd_en;
        rd_sel_t rd_sel;
        dp_op_t  op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sel_ok;
        logic is_on;
        logic out_free;
    } dp_status_t;

    // round(2^((key-57)/12) * 288.3584)
    localparam int FNUM_TABLE [128] = '{
        11, 11, 12, 13, 14, 14, 15, 16, 17,
        18, 19, 20, 21, 23, 24, 25, 27, 29, 30, 32, 34,
        36, 38, 40, 43, 45, 48, 51, 54, 57, 61, 64, 68,
        72, 76, 81, 86, 91, 96, 102, 108, 114, 121, 128, 136,
        144, 153, 162, 171, 182, 192, 204, 216, 229, 242, 257, 272,
        288, 306, 324, 343, 363, 385, 408, 432, 458, 485, 514, 544,
        577, 611, 647, 686, 727, 770, 816, 864, 915, 970, 1028, 1089,
        1153, 1222, 1295, 1372, 1453, 1540, 1631, 1728, 1831, 1940, 2055, 2177,
        2307, 2444, 2589, 2743, 2906, 3079, 3262, 3456, 3662, 3880, 4110, 4355,
        4614, 4888, 5179, 5487, 5813, 6159, 6525, 6913, 7324, 7759, 8221, 8710,
        9227, 9776, 10357, 10973, 11626, 12317, 13050, 13826, 14648, 15519, 16441
    };

    // Shadow contents left behind by chip setup.
    function automatic logic [DATA_W-1:0] shadow_reset(input logic [ADDR_W-1:0] addr);
        logic [DATA_W-1:0] val;
        val = '0;
        if (addr == ADDR_CTRL0 || addr == ADDR_CTRL1)
        begin
            val = SETUP_CTRL_VAL;
        end
        else if (addr >= BASE_FHI && {1'b0, addr} < 7'(BASE_FHI) + 7'(VOICES))
        begin
            val = SETUP_OCTAVE_VAL;
        end
        return val;
    endfunction

endpackage

@@ rtl/core/fva_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/fva_ctrl.sv @@
// Sequencer for the voice allocator: one command at a time, one register write per step.
// Depends on fva_pkg.
module fva_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  fva_pkg::dp_status_t    status,
    output fva_pkg::ctrl_cmd_t     ctrl
);

    fva_pkg::state_t state_reg;
    fva_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fva_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctrl.accept = 1'b0;
        ctrl.rd_en  = 1'b0;
        ctrl.rd_sel = fva_pkg::RD_KEY;
        ctrl.op     = fva_pkg::OP_NONE;
        cmd_stall   = 1'b1;
        case (state_reg)
            fva_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = status.sel_ok ? fva_pkg::ST_READ : fva_pkg::ST_REJECT;
                end
            end
            fva_pkg::ST_READ:
            begin
                ctrl.rd_en  = 1'b1;
                ctrl.rd_sel = fva_pkg::RD_KEY;
                state_next  = status.is_on ? fva_pkg::ST_FLO : fva_pkg::ST_OFF;
            end
            fva_pkg::ST_FLO:
            begin
                if (status.out_free)
                begin
                    ctrl.op     = fva_pkg::OP_FLO;
                    ctrl.rd_en  = 1'b1;
                    ctrl.rd_sel = fva_pkg::RD_FHI;
                    state_next  = fva_pkg::ST_FHI;
                end
            end
            fva_pkg::ST_FHI:
            begin
                if (status.out_free)
                begin
                    ctrl.op     = fva_pkg::OP_FHI;
                    ctrl.rd_en  = 1'b1;
                    ctrl.rd_sel = fva_pkg::RD_VOL;
                    state_next  = fva_pkg::ST_VOL;
                end
            end
            fva_pkg::ST_VOL:
            begin
                if (status.out_free)
                begin
                    ctrl.op    = fva_pkg::OP_VOL;
                    state_next = fva_pkg::ST_KEY;
                end
            end
            fva_pkg::ST_KEY:
            begin
                if (status.out_free)
                begin
                    ctrl.op    = fva_pkg::OP_KEY_ON;
                    state_next = fva_pkg::ST_IDLE;
                end
            end
            fva_pkg::ST_OFF:
            begin
                if (status.out_free)
                begin
                    ctrl.op    = fva_pkg::OP_KEY_OFF;
                    state_next = fva_pkg::ST_IDLE;
                end
            end
            fva_pkg::ST_REJECT:
            begin
                if (status.out_free)
                begin
                    ctrl.op    = fva_pkg::OP_REJECT;
                    state_next = fva_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fva_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/fva_dp.sv @@
// Datapath: voice search, busy flags, shadow register RAM, read-modify-write and result register.
// Depends on fva_pkg and fva_ram.
module fva_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fva_pkg::ctrl_cmd_t                 ctrl,
    output fva_pkg::dp_status_t                status,
    input  logic                               command,
    input  logic [fva_pkg::KEY_W-1:0]          key,
    input  logic [fva_pkg::VEL_W-1:0]          velocity,
    input  logic [fva_pkg::VOICE_W-1:0]        release_voice,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [1:0]                         kind,
    output logic [fva_pkg::ADDR_W-1:0]         reg_address,
    output logic [fva_pkg::DATA_W-1:0]         reg_data,
    output logic [fva_pkg::VOICE_W-1:0]        voice,
    output logic                               last
);

    // voice state
    logic [fva_pkg::VOICES-1:0]    busy_reg;
    logic [fva_pkg::VOICE_W-1:0]   last_voice_reg;

    // current command
    logic                          is_on_reg;
    logic [fva_pkg::VOICE_W-1:0]   voice_reg;
    logic [fva_pkg::FNUM_W-1:0]    fnum_reg;
    logic [fva_pkg::VOL_W-1:0]     vol_reg;

    // shadow access
    logic [fva_pkg::SHADOW_REGS-1:0] valid_reg;
    logic [fva_pkg::ADDR_W-1:0]      rd_addr_reg;
    logic                            rd_shadow_reg;
    logic                            rd_hit_reg;
    logic [fva_pkg::DATA_W-1:0]      key_byte_reg;
    logic [fva_pkg::ADDR_W-1:0]      key_addr_reg;

    // result register
    logic                          res_valid_reg;
    fva_pkg::kind_t                kind_reg;
    logic [fva_pkg::ADDR_W-1:0]    addr_reg;
    logic [fva_pkg::DATA_W-1:0]    data_reg;
    logic [fva_pkg::VOICE_W-1:0]   voice_out_reg;
    logic                          last_reg;

    logic                          found;
    logic [fva_pkg::VOICE_W-1:0]   found_voice;
    logic                          in_range;
    logic                          is_on_in;
    logic [fva_pkg::TABLE_W-1:0]   fnum_full;

    logic [fva_pkg::ADDR_W-1:0]    rd_base;
    logic [fva_pkg::ADDR_W-1:0]    rd_addr;
    logic                          rd_in_shadow;
    logic [fva_pkg::DATA_W-1:0]    ram_rdata;
    logic [fva_pkg::DATA_W-1:0]    cur_byte;
    logic [fva_pkg::DATA_W-1:0]    new_byte;
    logic [fva_pkg::ADDR_W-1:0]    wr_addr;
    logic                          wr_in_shadow;
    logic                          is_write;
    logic                          wr_en;

    // round-robin search from the voice after the last one allocated
    always_comb
    begin
        logic [fva_pkg::VOICE_W:0] cand;
        found       = 1'b0;
        found_voice = '0;
        cand        = '0;
        for (int c = 0; c < fva_pkg::VOICES; c++)
        begin
            cand = 5'(last_voice_reg) + 5'd1 + 5'(c);
            if (cand >= 5'(fva_pkg::VOICES))
            begin
                cand = cand - 5'(fva_pkg::VOICES);
            end
            if (!found && !busy_reg[cand[fva_pkg::VOICE_W-1:0]])
            begin
                found       = 1'b1;
                found_voice = cand[fva_pkg::VOICE_W-1:0];
            end
        end
    end

    assign in_range  = {1'b0, release_voice} < 5'(fva_pkg::VOICES);
    assign is_on_in  = (command == fva_pkg::CMD_NOTE_ON);
    assign fnum_full = fva_pkg::TABLE_W'(fva_pkg::FNUM_TABLE[key]);

    assign status.sel_ok   = is_on_in ? found : in_range;
    assign status.is_on    = is_on_reg;
    assign status.out_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_on_reg <= 1'b0;
        end
        else if (ctrl.accept)
        begin
            is_on_reg <= is_on_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            voice_reg <= is_on_in ? found_voice : release_voice;
            fnum_reg  <= fnum_full[fva_pkg::FNUM_W-1:0];
            vol_reg   <= fva_pkg::VOL_MAX - velocity[fva_pkg::VOL_W-1:0];
        end
    end

    // read port address
    always_comb
    begin
        case (ctrl.rd_sel)
            fva_pkg::RD_KEY: rd_base = fva_pkg::BASE_KEY;
            fva_pkg::RD_FHI: rd_base = fva_pkg::BASE_FHI;
            fva_pkg::RD_VOL: rd_base = fva_pkg::BASE_VOL;
            default:         rd_base = fva_pkg::BASE_KEY;
        endcase
    end

    assign rd_addr      = fva_pkg::ADDR_W'(rd_base + {2'b00, voice_reg});
    assign rd_in_shadow = {1'b0, rd_addr} < 7'(fva_pkg::SHADOW_REGS);

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_addr_reg   <= rd_addr;
            rd_shadow_reg <= rd_in_shadow;
            rd_hit_reg    <= rd_in_shadow && valid_reg[rd_addr[fva_pkg::SHADOW_AW-1:0]];
        end
    end

    // unwritten entries read as their setup value
    always_comb
    begin
        if (!rd_shadow_reg)
        begin
            cur_byte = '0;
        end
        else if (rd_hit_reg)
        begin
            cur_byte = ram_rdata;
        end
        else
        begin
            cur_byte = fva_pkg::shadow_reset(rd_addr_reg);
        end
    end

    always_comb
    begin
        new_byte = '0;
        wr_addr  = rd_addr_reg;
        is_write = 1'b1;
        case (ctrl.op)
            fva_pkg::OP_FLO:     new_byte = {cur_byte[7:4], fnum_reg[3:0]};
            fva_pkg::OP_FHI:     new_byte = {cur_byte[7:5], fnum_reg[8:4]};
            fva_pkg::OP_VOL:     new_byte = {cur_byte[7:4], vol_reg};
            fva_pkg::OP_KEY_ON:
            begin
                new_byte = key_byte_reg | fva_pkg::KEY_DOWN_BIT;
                wr_addr  = key_addr_reg;
            end
            fva_pkg::OP_KEY_OFF: new_byte = cur_byte & ~fva_pkg::KEY_DOWN_BIT;
            default:             is_write = 1'b0;
        endcase
    end

    assign wr_in_shadow = {1'b0, wr_addr} < 7'(fva_pkg::SHADOW_REGS);
    assign wr_en        = is_write && wr_in_shadow;

    // key-down goes into the byte just written by the low-nibble step
    always_ff @(posedge clk)
    begin
        if (ctrl.op == fva_pkg::OP_FLO)
        begin
            key_byte_reg <= rd_shadow_reg ? new_byte : '0;
            key_addr_reg <= rd_addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr[fva_pkg::SHADOW_AW-1:0]] <= 1'b1;
        end
    end

    fva_ram #(
        .WIDTH (fva_pkg::DATA_W),
        .DEPTH (fva_pkg::SHADOW_REGS)
    ) u_shadow (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr[fva_pkg::SHADOW_AW-1:0]),
        .wdata (new_byte),
        .re    (ctrl.rd_en),
        .raddr (rd_addr[fva_pkg::SHADOW_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= '0;
            last_voice_reg <= '0;
        end
        else if (ctrl.op == fva_pkg::OP_KEY_ON)
        begin
            busy_reg[voice_reg] <= 1'b1;
            last_voice_reg      <= voice_reg;
        end
        else if (ctrl.op == fva_pkg::OP_KEY_OFF)
        begin
            busy_reg[voice_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctrl.op != fva_pkg::OP_NONE)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == fva_pkg::OP_REJECT)
        begin
            kind_reg      <= is_on_reg ? fva_pkg::KIND_NO_VOICE : fva_pkg::KIND_BAD_VOICE;
            addr_reg      <= '0;
            data_reg      <= '0;
            voice_out_reg <= is_on_reg ? '0 : voice_reg;
            last_reg      <= 1'b1;
        end
        else if (ctrl.op != fva_pkg::OP_NONE)
        begin
            kind_reg      <= fva_pkg::KIND_WRITE;
            addr_reg      <= wr_addr;
            data_reg      <= new_byte;
            voice_out_reg <= voice_reg;
            last_reg      <= (ctrl.op == fva_pkg::OP_KEY_ON) || (ctrl.op == fva_pkg::OP_KEY_OFF);
        end
    end

    assign res_valid   = res_valid_reg;
    assign kind        = kind_reg;
    assign reg_address = addr_reg;
    assign reg_data    = data_reg;
    assign voice       = voice_out_reg;
    assign last        = last_reg;

endmodule

@@ rtl/core/fm_voice_allocator_core.sv @@
// Round-robin voice allocator for a 9-voice FM synth chip: top level.
// Depends on fva_pkg, fva_ctrl, fva_dp (which holds fva_ram).
//
// Takes one note-on/note-off transaction at a time and turns it into chip
// register write transactions. Up to its last result, a note-on passes
// search and capture, one shadow RAM read, then four read-modify-write
// steps, one per cycle unless the result channel stalls, each paced by the
// RAM's single read and single write port; a note-off passes capture, the
// read and one write step, and a rejected command (no free voice, voice out
// of range) capture and one rejection step. The next command is taken in
// the cycle after the last result is loaded, even while that result still
// waits in the output register. A stall on the result channel holds the
// sequencer step by step. The shadow RAM needs no clearing pass after
// reset: per-entry valid bits make untouched entries read as the values the
// chip setup leaves behind, so commands are taken right out of reset.
module fm_voice_allocator_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // command channel
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic                         command,
    input  logic [fva_pkg::KEY_W-1:0]    key,
    input  logic [fva_pkg::VEL_W-1:0]    velocity,
    input  logic [fva_pkg::VOICE_W-1:0]  release_voice,
    // result channel
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [1:0]                   kind,
    output logic [fva_pkg::ADDR_W-1:0]   reg_address,
    output logic [fva_pkg::DATA_W-1:0]   reg_data,
    output logic [fva_pkg::VOICE_W-1:0]  voice,
    output logic                         last
);

    fva_pkg::ctrl_cmd_t  ctrl;
    fva_pkg::dp_status_t status;

    // sequencer: one state per emitted register write
    fva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    // search, shadow registers, result register
    fva_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .status        (status),
        .command       (command),
        .key           (key),
        .velocity      (velocity),
        .release_voice (release_voice),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .kind          (kind),
        .reg_address   (reg_address),
        .reg_data      (reg_data),
        .voice         (voice),
        .last          (last)
    );

    // the block is busy in the cycle after a command is accepted
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("command accepted back to back");

    // a non-final result means the command is still in progress
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && !last) |-> cmd_stall)
        else $error("command released before its last result");

    // rejections are always single, final results
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && kind != fva_pkg::KIND_WRITE) |-> last)
        else $error("rejection not marked last");

    // register writes only target per-voice registers
    a_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && kind == fva_pkg::KIND_WRITE) |-> (reg_address >= fva_pkg::BASE_FHI))
        else $error("register write to non-voice address");

endmodule
